FILE: rtl/pwmtc_pkg.sv
// pwmtc_pkg: shared types and constants for the PWM period/duty to timer counts core.
// Depends on nothing; imported by pwm_period_duty_to_timer_counts_core.
`default_nettype none

package pwmtc_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FREQ,
        ST_RATE,
        ST_SEARCH,
        ST_TICK,
        ST_CNT,
        ST_CMP,
        ST_FINISH
    } state_t;

    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_UNCHANGED   = 3'd1;
    localparam logic [2:0] STATUS_PERIOD_LONG = 3'd2;
    localparam logic [2:0] STATUS_DUTY_LONG   = 3'd3;
    localparam logic [2:0] STATUS_BAD_RATE    = 3'd4;
    localparam logic [2:0] STATUS_TOO_SHORT   = 3'd5;

    localparam logic [1:0] CLASS_ZERO  = 2'd0;
    localparam logic [1:0] CLASS_PULSE = 2'd1;
    localparam logic [1:0] CLASS_FULL  = 2'd2;

    localparam logic [2:0] REG_SOURCE_CLOCK   = 3'd0;
    localparam logic [2:0] REG_PRESCALER_LOW  = 3'd1;
    localparam logic [2:0] REG_PRESCALER_HIGH = 3'd2;
    localparam logic [2:0] REG_COUNTER_WIDTH  = 3'd3;
    localparam logic [2:0] REG_DIVIDER_BASE   = 3'd4;

    localparam logic [31:0] NS_PER_S            = 32'd1000000000;
    localparam logic [2:0]  SEARCH_LIMIT        = 3'd4;
    localparam logic [5:0]  FULL_WIDTH          = 6'd32;
    localparam logic [5:0]  COUNTER_WIDTH_RESET = 6'd32;
    localparam logic [4:0]  DIV_LAST_STEP       = 5'd31;

endpackage

`default_nettype wire

FILE: rtl/pwm_period_duty_to_timer_counts_core.sv
// pwm_period_duty_to_timer_counts_core: turns a PWM period/duty request into timer reload values.
// Depends on pwmtc_pkg; one shared restoring divider under a small sequencer.
//
//  channel   | handshake              | words
//  ----------+------------------------+-------------------------------------------
//  request   | start / busy           | channel, period_len, duty_ns
//  result    | done (one-cycle strobe)| status, count_reload, compare_reload,
//            |                        | divider_select, divider_update, duty_class,
//            |                        | class_changed, tick_ns
//  config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A request is taken when start is high and busy low; busy then stays high until done.
// Each division on the shared divider is one load step followed by 32 quotient-bit steps.
// busy spans up to five divisions (frequency, rate, tick, count, compare) plus the width search
// on a new period, count and compare on a kept one, and only the check on a rejected or unchanged request.
// done rises as busy falls; an out-of-range channel returns no word.
// Reset (rst_n, asynchronous) clears control state and the per-channel cache at once.
// Results are strobed for one cycle and the receiver cannot stall them.
`default_nettype none

module pwm_period_duty_to_timer_counts_core
    import pwmtc_pkg::*;
#(
    parameter int CHANNEL_COUNT = 5
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  channel,
    input  wire logic [30:0] period_len,
    input  wire logic [30:0] duty_ns,
    output logic             done,
    output logic [2:0]       status,
    output logic [31:0]      count_reload,
    output logic [31:0]      compare_reload,
    output logic [2:0]       divider_select,
    output logic             divider_update,
    output logic [1:0]       duty_class,
    output logic             class_changed,
    output logic [29:0]      tick_ns,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int         CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam logic [3:0] CH_LIMIT = 4'(CHANNEL_COUNT);

    // configuration
    logic [31:0] src_clk_reg;
    logic [7:0]  pre_low_reg;
    logic [7:0]  pre_high_reg;
    logic [5:0]  cw_reg;
    logic        base_reg;

    // per-channel cache
    logic [30:0] cached_period_reg [CHANNEL_COUNT];
    logic [30:0] cached_duty_reg   [CHANNEL_COUNT];
    logic [29:0] cached_tick_reg   [CHANNEL_COUNT];
    logic [1:0]  cached_class_reg  [CHANNEL_COUNT];
    logic        cache_we;

    // sequencer and working registers
    state_t      state_reg, state_next;
    logic        done_reg, done_next;
    logic [2:0]  ch_reg, ch_next;
    logic [30:0] period_reg, period_next;
    logic [30:0] duty_reg, duty_next;
    logic [29:0] freq_reg, freq_next;
    logic [31:0] rate_reg, rate_next;
    logic [2:0]  exp_reg, exp_next;
    logic [29:0] tick_reg, tick_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] cmp_reg, cmp_next;
    logic [2:0]  sel_reg, sel_next;
    logic        upd_reg, upd_next;

    // shared divider
    logic        div_run_reg, div_run_next;
    logic [4:0]  div_cnt_reg, div_cnt_next;
    logic [31:0] div_rem_reg, div_rem_next;
    logic [31:0] div_quo_reg, div_quo_next;
    logic [31:0] div_den_reg, div_den_next;
    logic [31:0] div_num;
    logic [31:0] div_den;
    logic [32:0] rem_shift;
    logic [32:0] rem_sub;
    logic        div_bit;
    logic [31:0] quo_step;
    logic        div_last;

    // result word
    logic [2:0]  out_status_reg, out_status_next;
    logic [31:0] out_reload_reg, out_reload_next;
    logic [31:0] out_compare_reg, out_compare_next;
    logic [2:0]  out_sel_reg, out_sel_next;
    logic        out_upd_reg, out_upd_next;
    logic [1:0]  out_class_reg, out_class_next;
    logic        out_changed_reg, out_changed_next;
    logic [29:0] out_tick_reg, out_tick_next;

    // helpers
    logic [CH_IDX_W-1:0] ch_idx;
    logic [30:0] cp;
    logic [30:0] cd;
    logic [29:0] ct;
    logic [1:0]  cc;
    logic [7:0]  pre_sel;
    logic [31:0] scaled_rate;
    logic [6:0]  shamt;
    logic        search_hit;
    logic [1:0]  cls;

    assign ch_idx      = ch_reg[CH_IDX_W-1:0];
    assign cp          = cached_period_reg[ch_idx];
    assign cd          = cached_duty_reg[ch_idx];
    assign ct          = cached_tick_reg[ch_idx];
    assign cc          = cached_class_reg[ch_idx];
    assign pre_sel     = (ch_reg >= 3'd2) ? pre_high_reg : pre_low_reg;
    assign scaled_rate = rate_reg >> exp_reg;
    assign shamt       = {1'b0, cw_reg} + {4'b0, exp_reg};
    assign search_hit  = (rate_reg >> shamt) < {2'b0, freq_reg};

    assign rem_shift = {div_rem_reg, div_quo_reg[31]};
    assign rem_sub   = rem_shift - {1'b0, div_den_reg};
    assign div_bit   = ~rem_sub[32];
    assign quo_step  = {div_quo_reg[30:0], div_bit};
    assign div_last  = (div_cnt_reg == DIV_LAST_STEP);

    // operands for the division that the current state needs
    always_comb
    begin
        div_num = '0;
        div_den = 32'd1;
        case (state_reg)
            ST_FREQ:
            begin
                div_num = NS_PER_S;
                div_den = {1'b0, period_reg};
            end
            ST_RATE:
            begin
                div_num = src_clk_reg;
                div_den = {23'b0, {1'b0, pre_sel} + 9'd1};
            end
            ST_TICK:
            begin
                div_num = NS_PER_S;
                div_den = scaled_rate;
            end
            ST_CNT:
            begin
                div_num = {1'b0, period_reg} + {3'b0, tick_reg[29:1]};
                div_den = {2'b0, tick_reg};
            end
            ST_CMP:
            begin
                div_num = {1'b0, duty_reg} + {3'b0, tick_reg[29:1]};
                div_den = {2'b0, tick_reg};
            end
            default:
            begin
                div_num = '0;
                div_den = 32'd1;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        done_next        = 1'b0;
        ch_next          = ch_reg;
        period_next      = period_reg;
        duty_next        = duty_reg;
        freq_next        = freq_reg;
        rate_next        = rate_reg;
        exp_next         = exp_reg;
        tick_next        = tick_reg;
        cnt_next         = cnt_reg;
        cmp_next         = cmp_reg;
        sel_next         = sel_reg;
        upd_next         = upd_reg;
        out_status_next  = out_status_reg;
        out_reload_next  = out_reload_reg;
        out_compare_next = out_compare_reg;
        out_sel_next     = out_sel_reg;
        out_upd_next     = out_upd_reg;
        out_class_next   = out_class_reg;
        out_changed_next = out_changed_reg;
        out_tick_next    = out_tick_reg;
        cache_we         = 1'b0;
        cls              = CLASS_PULSE;

        div_run_next = div_run_reg;
        div_cnt_next = div_cnt_reg;
        div_rem_next = div_rem_reg;
        div_quo_next = div_quo_reg;
        div_den_next = div_den_reg;

        if (div_run_reg)
        begin
            div_rem_next = div_bit ? rem_sub[31:0] : rem_shift[31:0];
            div_quo_next = quo_step;
            div_cnt_next = div_cnt_reg + 5'd1;
            if (div_last)
            begin
                div_run_next = 1'b0;
            end
        end
        else if (state_reg inside {ST_FREQ, ST_RATE, ST_TICK, ST_CNT, ST_CMP})
        begin
            div_rem_next = '0;
            div_quo_next = div_num;
            div_den_next = div_den;
            div_cnt_next = '0;
            div_run_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ch_next     = channel;
                    period_next = period_len;
                    duty_next   = duty_ns;
                    state_next  = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                sel_next         = '0;
                upd_next         = 1'b0;
                out_reload_next  = '0;
                out_compare_next = '0;
                out_sel_next     = '0;
                out_upd_next     = 1'b0;
                out_class_next   = CLASS_ZERO;
                out_changed_next = 1'b0;
                out_tick_next    = '0;
                if ({1'b0, ch_reg} >= CH_LIMIT)
                begin
                    state_next = ST_IDLE;
                end
                else if ({1'b0, period_reg} > NS_PER_S)
                begin
                    out_status_next = STATUS_PERIOD_LONG;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if (duty_reg > period_reg)
                begin
                    out_status_next = STATUS_DUTY_LONG;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if (period_reg == cp && duty_reg == cd)
                begin
                    out_status_next = STATUS_UNCHANGED;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if (period_reg != cp)
                begin
                    if (period_reg == '0)
                    begin
                        out_status_next = STATUS_BAD_RATE;
                        done_next       = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FREQ;
                    end
                end
                else
                begin
                    // kept period: reuse the cached tick
                    tick_next = ct;
                    if (ct == '0)
                    begin
                        out_status_next = STATUS_BAD_RATE;
                        done_next       = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_CNT;
                    end
                end
            end

            ST_FREQ:
            begin
                if (div_run_reg && div_last)
                begin
                    freq_next  = quo_step[29:0];
                    state_next = ST_RATE;
                end
            end

            ST_RATE:
            begin
                if (div_run_reg && div_last)
                begin
                    rate_next  = quo_step;
                    exp_next   = {2'b0, base_reg};
                    state_next = (cw_reg < FULL_WIDTH) ? ST_SEARCH : ST_TICK;
                end
            end

            ST_SEARCH:
            begin
                if (exp_reg >= SEARCH_LIMIT || search_hit)
                begin
                    state_next = ST_TICK;
                end
                else
                begin
                    exp_next = exp_reg + 3'd1;
                end
            end

            ST_TICK:
            begin
                if (!div_run_reg)
                begin
                    sel_next = exp_reg - {2'b0, base_reg};
                    upd_next = 1'b1;
                    if (scaled_rate == '0)
                    begin
                        div_run_next     = 1'b0;
                        out_status_next  = STATUS_BAD_RATE;
                        out_reload_next  = '0;
                        out_compare_next = '0;
                        out_sel_next     = exp_reg - {2'b0, base_reg};
                        out_upd_next     = 1'b1;
                        out_class_next   = CLASS_ZERO;
                        out_changed_next = 1'b0;
                        out_tick_next    = '0;
                        done_next        = 1'b1;
                        state_next       = ST_IDLE;
                    end
                end
                else if (div_last)
                begin
                    if (quo_step == '0)
                    begin
                        out_status_next  = STATUS_BAD_RATE;
                        out_reload_next  = '0;
                        out_compare_next = '0;
                        out_sel_next     = sel_reg;
                        out_upd_next     = upd_reg;
                        out_class_next   = CLASS_ZERO;
                        out_changed_next = 1'b0;
                        out_tick_next    = '0;
                        done_next        = 1'b1;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        tick_next  = quo_step[29:0];
                        state_next = ST_CNT;
                    end
                end
            end

            ST_CNT:
            begin
                if (div_run_reg && div_last)
                begin
                    cnt_next = quo_step;
                    if (quo_step <= 32'd1)
                    begin
                        out_status_next  = STATUS_TOO_SHORT;
                        out_reload_next  = '0;
                        out_compare_next = '0;
                        out_sel_next     = sel_reg;
                        out_upd_next     = upd_reg;
                        out_class_next   = CLASS_ZERO;
                        out_changed_next = 1'b0;
                        out_tick_next    = tick_reg;
                        done_next        = 1'b1;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_CMP;
                    end
                end
            end

            ST_CMP:
            begin
                if (div_run_reg && div_last)
                begin
                    cmp_next   = quo_step;
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (cmp_reg == '0)
                begin
                    cls = CLASS_ZERO;
                end
                else if (cmp_reg == cnt_reg)
                begin
                    cls = CLASS_FULL;
                end
                else
                begin
                    cls = CLASS_PULSE;
                end
                // zero duty still leaves one tick of compare headroom
                out_compare_next = (cmp_reg == '0) ? cnt_reg - 32'd2
                                                   : cnt_reg - cmp_reg - 32'd1;
                out_status_next  = STATUS_OK;
                out_reload_next  = cnt_reg - 32'd1;
                out_sel_next     = sel_reg;
                out_upd_next     = upd_reg;
                out_class_next   = cls;
                out_changed_next = (cls != cc);
                out_tick_next    = tick_reg;
                cache_we         = 1'b1;
                done_next        = 1'b1;
                state_next       = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state, configuration and cache
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            done_reg     <= 1'b0;
            div_run_reg  <= 1'b0;
            src_clk_reg  <= '0;
            pre_low_reg  <= '0;
            pre_high_reg <= '0;
            cw_reg       <= COUNTER_WIDTH_RESET;
            base_reg     <= 1'b0;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                cached_period_reg[i] <= '0;
                cached_duty_reg[i]   <= '0;
                cached_tick_reg[i]   <= '0;
                cached_class_reg[i]  <= CLASS_ZERO;
            end
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            div_run_reg <= div_run_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SOURCE_CLOCK:   src_clk_reg  <= cfg_data;
                    REG_PRESCALER_LOW:  pre_low_reg  <= cfg_data[7:0];
                    REG_PRESCALER_HIGH: pre_high_reg <= cfg_data[7:0];
                    REG_COUNTER_WIDTH:  cw_reg       <= cfg_data[5:0];
                    REG_DIVIDER_BASE:   base_reg     <= cfg_data[0];
                    default:            ;
                endcase
            end
            if (cache_we)
            begin
                cached_period_reg[ch_idx] <= period_reg;
                cached_duty_reg[ch_idx]   <= duty_reg;
                cached_tick_reg[ch_idx]   <= tick_reg;
                cached_class_reg[ch_idx]  <= cls;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        ch_reg          <= ch_next;
        period_reg      <= period_next;
        duty_reg        <= duty_next;
        freq_reg        <= freq_next;
        rate_reg        <= rate_next;
        exp_reg         <= exp_next;
        tick_reg        <= tick_next;
        cnt_reg         <= cnt_next;
        cmp_reg         <= cmp_next;
        sel_reg         <= sel_next;
        upd_reg         <= upd_next;
        div_cnt_reg     <= div_cnt_next;
        div_rem_reg     <= div_rem_next;
        div_quo_reg     <= div_quo_next;
        div_den_reg     <= div_den_next;
        out_status_reg  <= out_status_next;
        out_reload_reg  <= out_reload_next;
        out_compare_reg <= out_compare_next;
        out_sel_reg     <= out_sel_next;
        out_upd_reg     <= out_upd_next;
        out_class_reg   <= out_class_next;
        out_changed_reg <= out_changed_next;
        out_tick_reg    <= out_tick_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign done           = done_reg;
    assign status         = out_status_reg;
    assign count_reload   = out_reload_reg;
    assign compare_reload = out_compare_reg;
    assign divider_select = out_sel_reg;
    assign divider_update = out_upd_reg;
    assign duty_class     = out_class_reg;
    assign class_changed  = out_changed_reg;
    assign tick_ns        = out_tick_reg;

`ifndef NO_ASSERTIONS
    a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_div_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !div_run_reg)
        else $error("divider running while idle");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == STATUS_UNCHANGED || status == STATUS_PERIOD_LONG
                 || status == STATUS_DUTY_LONG)
        |-> count_reload == '0 && compare_reload == '0 && tick_ns == '0 && !divider_update)
        else $error("rejected word carries nonzero fields");

    a_ok_counts: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STATUS_OK |-> count_reload != '0 && tick_ns != '0)
        else $error("ok word with empty reload or tick");
`endif

endmodule

`default_nettype wire
